### rtl/mmc3_pkg.sv
// Shared types and constants for the MMC3 bank mapper with scanline interrupt.
// No dependencies; compiled before every other file of the block.
package mmc3_pkg;

	// Kinds of bus access carried by one input beat
	localparam logic [1:0] ACT_CPU_WR    = 2'd0;
	localparam logic [1:0] ACT_CPU_RD    = 2'd1;
	localparam logic [1:0] ACT_PPU_RD    = 2'd2;
	localparam logic [1:0] ACT_PPU_FETCH = 2'd3;

	// Memories an access can be steered to
	localparam logic [2:0] TGT_PRG_ROM = 3'd0;
	localparam logic [2:0] TGT_PRG_RAM = 3'd1;
	localparam logic [2:0] TGT_CHR_ROM = 3'd2;
	localparam logic [2:0] TGT_CHR_RAM = 3'd3;
	localparam logic [2:0] TGT_NONE    = 3'd4;

	// Nametable arrangement reported with every result
	localparam logic [1:0] MIR_HORZ = 2'd0;
	localparam logic [1:0] MIR_VERT = 2'd1;
	localparam logic [1:0] MIR_FOUR = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_PRG_PAGES   = 2'd0;
	localparam logic [1:0] CFG_CHR_PAGES   = 2'd1;
	localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;
	localparam logic [1:0] CFG_MIRROR_INIT = 2'd3;

	// Mapper register decode, CPU space at 0x8000 and above
	localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
	localparam logic [15:0] REG_BANK_SEL    = 16'h8000;
	localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
	localparam logic [15:0] REG_MIRROR      = 16'hA000;
	localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
	localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
	localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
	localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

	// Scanline value that means no line has been seen yet
	localparam logic [8:0] NO_LINE = 9'd511;

	// Bank register contents after reset, entry 0 in the lowest byte
	localparam logic [7:0][7:0] BANK_RESET = {8'd1, 8'd0, 8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] address;
		logic [7:0]  write_data;
		logic [3:0]  pattern_row;
		logic        first_plane;
		logic [8:0]  scanline;
	} item_t;

	// Mapper state and configuration seen by the address translator
	typedef struct packed {
		logic [7:0][7:0] bank;
		logic            chr_invert;
		logic            prg_swap;
		logic [5:0]      prg_pages;
		logic [5:0]      chr_pages;
		logic            four_screen;
	} map_ctl_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [18:0] mem_address;
	} xlate_t;

endpackage

### rtl/mmc3_bank_mapper_irq.sv
// Top level of the MMC3 bank mapper with scanline interrupt counter.
// Depends on mmc3_pkg and mmc3_xlate.
//
//  Channel  Direction  Signals                          Contents
//  s_axis   in         tvalid tready tdata[39:0] tuser  one bus access per beat
//  m_axis   out        tvalid tready tdata[31:0]        one translation per beat
//  cfg      in         cfg_we cfg_index[1:0] cfg_data   page counts, screen layout
//
// Every accepted beat produces exactly one result beat. It is held in the input register,
// then in the result register. A new beat can be accepted in every cycle unless m_axis is
// stalled with both registers full; while m_axis is ready the rate is one access per
// clock. The path from the input register to the result register holds the address
// translator and the mapper register and counter update. When the result register is
// full and m_axis_tready is low, the input register holds its beat and s_axis_tready
// falls only once that register is occupied too. Reset (arst_n low) restores the
// power-up bank layout, clears the interrupt logic and empties both pipeline registers.
// Configuration is meant to be written only while no beat is in flight.
module mmc3_bank_mapper_irq #(
	parameter int MAX_PRG_PAGES = 32,
	parameter int MAX_CHR_PAGES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// address[15:0], write_data[23:16], pattern_row[27:24], first_plane[28],
	// scanline[37:29], zero fill [39:38]
	input  logic [39:0] s_axis_tdata,
	// action[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// target[2:0], mem_address[21:3], irq[22], mirroring[24:23], zero fill [31:25]
	output logic [31:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);
	import mmc3_pkg::*;

	// Configuration registers
	logic [5:0] prg_pages_q;
	logic [5:0] chr_pages_q;
	logic       four_screen_q;

	// Mapper state
	logic [7:0][7:0] bank_q, bank_d;
	logic            chr_invert_q, chr_invert_d;
	logic            prg_swap_q, prg_swap_d;
	logic [2:0]      reg_pointer_q, reg_pointer_d;
	logic [7:0]      irq_latch_q, irq_latch_d;
	logic [7:0]      irq_count_q, irq_count_d;
	logic            irq_enable_q, irq_enable_d;
	logic            irq_pending_q, irq_pending_d;
	logic [8:0]      last_line_q, last_line_d;
	logic            mirror_vert_q, mirror_vert_d;

	// Pipeline
	logic        valid_s1;
	item_t       item_s1;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic        advance;

	map_ctl_t ctl;
	xlate_t   xres;
	logic     reg_write;
	logic     line_clock;
	logic [1:0] mirroring;

	// The input register moves on whenever the result register is free or
	// is being emptied in this cycle.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.action      <= s_axis_tuser;
			item_s1.address     <= s_axis_tdata[15:0];
			item_s1.write_data  <= s_axis_tdata[23:16];
			item_s1.pattern_row <= s_axis_tdata[27:24];
			item_s1.first_plane <= s_axis_tdata[28];
			item_s1.scanline    <= s_axis_tdata[37:29];
		end
		if (advance)
			out_data_q <= {7'd0, mirroring, irq_pending_d, xres.mem_address, xres.target};
	end

	// Translation uses the state left by all earlier beats.
	assign ctl.bank        = bank_q;
	assign ctl.chr_invert  = chr_invert_q;
	assign ctl.prg_swap    = prg_swap_q;
	assign ctl.prg_pages   = prg_pages_q;
	assign ctl.chr_pages   = chr_pages_q;
	assign ctl.four_screen = four_screen_q;

	mmc3_xlate #(
		.MAX_PRG_PAGES(MAX_PRG_PAGES),
		.MAX_CHR_PAGES(MAX_CHR_PAGES)
	) u_xlate (
		.item(item_s1),
		.ctl (ctl),
		.res (xres)
	);

	// Register writes reach the mapper at 0x8000 and above; the interrupt
	// counter is clocked by a fetch from the upper pattern table on a line
	// that differs from the last one counted.
	assign reg_write  = (item_s1.action == ACT_CPU_WR) && item_s1.address[15];
	assign line_clock = (item_s1.action == ACT_PPU_FETCH) && item_s1.address[12]
	                 && (last_line_q != item_s1.scanline);

	always_comb begin
		bank_d        = bank_q;
		chr_invert_d  = chr_invert_q;
		prg_swap_d    = prg_swap_q;
		reg_pointer_d = reg_pointer_q;
		irq_latch_d   = irq_latch_q;
		irq_count_d   = irq_count_q;
		irq_enable_d  = irq_enable_q;
		irq_pending_d = irq_pending_q;
		last_line_d   = last_line_q;
		mirror_vert_d = mirror_vert_q;
		if (reg_write) begin
			case (item_s1.address & REG_DECODE_MASK)
				REG_BANK_SEL: begin
					chr_invert_d  = item_s1.write_data[7];
					prg_swap_d    = item_s1.write_data[6];
					reg_pointer_d = item_s1.write_data[2:0];
				end
				REG_BANK_DATA: bank_d[reg_pointer_q] = item_s1.write_data;
				REG_MIRROR: begin
					if (!four_screen_q)
						mirror_vert_d = !item_s1.write_data[0];
				end
				REG_IRQ_LATCH:  irq_latch_d = item_s1.write_data;
				REG_IRQ_RELOAD: irq_count_d = 8'd0;
				REG_IRQ_DISABLE: begin
					irq_enable_d  = 1'b0;
					irq_pending_d = 1'b0;
				end
				REG_IRQ_ENABLE: begin
					irq_enable_d = 1'b1;
					last_line_d  = NO_LINE;
				end
				default: ;
			endcase
		end
		if (line_clock) begin
			last_line_d = item_s1.scanline;
			if (irq_count_q == 8'd0) begin
				irq_count_d = irq_latch_q;
			end else begin
				irq_count_d = irq_count_q - 8'd1;
				// The flag is sticky: only a disable write or reset clears it.
				if (irq_count_q == 8'd1 && irq_enable_q)
					irq_pending_d = 1'b1;
			end
		end
	end

	assign mirroring = four_screen_q ? MIR_FOUR : (mirror_vert_d ? MIR_VERT : MIR_HORZ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_pages_q   <= 6'd32;
			chr_pages_q   <= 6'd32;
			four_screen_q <= 1'b0;
			bank_q        <= BANK_RESET;
			chr_invert_q  <= 1'b0;
			prg_swap_q    <= 1'b0;
			reg_pointer_q <= 3'd0;
			irq_latch_q   <= 8'd0;
			irq_count_q   <= 8'd0;
			irq_enable_q  <= 1'b0;
			irq_pending_q <= 1'b0;
			last_line_q   <= NO_LINE;
			mirror_vert_q <= 1'b0;
		end else begin
			// The initial mirroring has no register of its own: it goes
			// straight into the live arrangement below.
			if (cfg_we) begin
				case (cfg_index)
					CFG_PRG_PAGES:   prg_pages_q   <= cfg_data;
					CFG_CHR_PAGES:   chr_pages_q   <= cfg_data;
					CFG_FOUR_SCREEN: four_screen_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (advance) begin
				bank_q        <= bank_d;
				chr_invert_q  <= chr_invert_d;
				prg_swap_q    <= prg_swap_d;
				reg_pointer_q <= reg_pointer_d;
				irq_latch_q   <= irq_latch_d;
				irq_count_q   <= irq_count_d;
				irq_enable_q  <= irq_enable_d;
				irq_pending_q <= irq_pending_d;
				last_line_q   <= last_line_d;
			end
			// A write of the initial mirroring loads the live arrangement and takes priority over a beat.
			if (cfg_we && cfg_index == CFG_MIRROR_INIT)
				mirror_vert_q <= cfg_data[0];
			else if (advance)
				mirror_vert_q <= mirror_vert_d;
		end
	end

endmodule

### rtl/mmc3_xlate.sv
// Address translator: steers one bus access to PRG ROM/RAM or CHR ROM/RAM, or to none.
// Purely combinational; depends on mmc3_pkg.
module mmc3_xlate #(
	parameter int MAX_PRG_PAGES = 32,
	parameter int MAX_CHR_PAGES = 32
) (
	input  mmc3_pkg::item_t    item,
	input  mmc3_pkg::map_ctl_t ctl,
	output mmc3_pkg::xlate_t   res
);
	import mmc3_pkg::*;

	localparam int PRG_BW = $clog2(2 * MAX_PRG_PAGES);
	localparam int CHR_BW = $clog2(8 * MAX_CHR_PAGES);

	logic [5:0]        prg_p;
	logic [5:0]        chr_p;
	logic [6:0]        prg_two;
	logic [PRG_BW-1:0] prg_mask;
	logic [PRG_BW-1:0] prg_second;
	logic [PRG_BW-1:0] prg_page;
	logic [1:0]        prg_slot;
	logic [18:0]       prg_addr;
	logic [CHR_BW-1:0] chr_mask;
	logic [CHR_BW-1:0] chr_page;
	logic              fetch;
	logic [15:0]       off;
	logic [3:0]        row_r;
	logic [12:0]       byte_sum;
	logic [2:0]        chr_slot;
	logic [2:0]        bank_idx;
	logic [7:0]        chr_raw;
	logic              prg_ram_ok;

	// Page counts limited to what the cartridge can hold
	always_comb begin
		if (ctl.prg_pages == 6'd0)
			prg_p = 6'd1;
		else if (ctl.prg_pages > 6'(MAX_PRG_PAGES))
			prg_p = 6'(MAX_PRG_PAGES);
		else
			prg_p = ctl.prg_pages;
		chr_p = (ctl.chr_pages > 6'(MAX_CHR_PAGES)) ? 6'(MAX_CHR_PAGES) : ctl.chr_pages;
	end

	assign prg_two    = {prg_p, 1'b0};
	assign prg_mask   = PRG_BW'(prg_two - 7'd1);
	assign prg_second = PRG_BW'(prg_two - 7'd2);
	assign chr_mask   = CHR_BW'({chr_p, 3'b000} - 9'd1);

	// PRG: slot 1 follows bank 7, slot 3 is fixed to the last bank, and
	// slots 0 and 2 trade bank 6 against the second-last bank.
	assign prg_slot = item.address[14:13];
	always_comb begin
		case (prg_slot)
			2'd1: prg_page = PRG_BW'(ctl.bank[7]) & prg_mask;
			2'd3: prg_page = prg_mask;
			default: begin
				if ((prg_slot == 2'd0) != ctl.prg_swap)
					prg_page = PRG_BW'(ctl.bank[6]) & prg_mask;
				else
					prg_page = prg_second;
			end
		endcase
	end
	assign prg_addr = 19'({prg_page, item.address[12:0]});

	// CHR: pattern fetches add the tile and plane offsets and use row mod 8
	assign fetch    = (item.action == ACT_PPU_FETCH);
	assign off      = item.address
	                + ((fetch && item.pattern_row[3]) ? 16'd16 : 16'd0)
	                + ((fetch && !item.first_plane) ? 16'd8 : 16'd0);
	assign row_r    = fetch ? {1'b0, item.pattern_row[2:0]} : item.pattern_row;
	assign byte_sum = off[12:0] + 13'(row_r);
	assign chr_slot = off[12:10] ^ {ctl.chr_invert, 2'b00};
	assign bank_idx = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
	assign chr_raw  = chr_slot[2] ? ctl.bank[bank_idx]
	                              : {ctl.bank[bank_idx][7:1], chr_slot[0]};
	assign chr_page = CHR_BW'(chr_raw) & chr_mask;

	assign prg_ram_ok = !ctl.four_screen && (item.address[15:13] == 3'b011);

	always_comb begin
		res.target      = TGT_NONE;
		res.mem_address = 19'd0;
		case (item.action)
			ACT_CPU_WR: begin
				if (prg_ram_ok) begin
					res.target      = TGT_PRG_RAM;
					res.mem_address = 19'(item.address[12:0]);
				end
			end
			ACT_CPU_RD: begin
				if (item.address[15]) begin
					res.target      = TGT_PRG_ROM;
					res.mem_address = prg_addr;
				end else if (prg_ram_ok) begin
					res.target      = TGT_PRG_RAM;
					res.mem_address = 19'(item.address[12:0]);
				end
			end
			default: begin
				if (chr_p != 6'd0) begin
					res.target      = TGT_CHR_ROM;
					res.mem_address = 19'({chr_page, byte_sum[9:0]});
				end else begin
					res.target      = TGT_CHR_RAM;
					res.mem_address = 19'(byte_sum);
				end
			end
		endcase
	end

endmodule

### rtl/mmc3_checker.sv
// Port-level checks for the MMC3 bank mapper result stream, with the bind
// that attaches them to mmc3_bank_mapper_irq. Depends on mmc3_pkg.
module mmc3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	import mmc3_pkg::*;

	// A stalled result beat holds its value.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// Target and mirroring codes stay within their defined sets.
	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] == TGT_PRG_ROM || m_axis_tdata[2:0] == TGT_PRG_RAM
		|| m_axis_tdata[2:0] == TGT_CHR_ROM || m_axis_tdata[2:0] == TGT_CHR_RAM
		|| m_axis_tdata[2:0] == TGT_NONE) && m_axis_tdata[24:23] != 2'd3)
		else $error("undefined target or mirroring code");

	// Register accesses and unmapped accesses carry a zero address.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == TGT_NONE |-> m_axis_tdata[21:3] == 19'd0)
		else $error("unmapped access with non-zero address");

	// PRG RAM and CHR RAM are 8 KiB each.
	a_ram_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] == TGT_PRG_RAM || m_axis_tdata[2:0] == TGT_CHR_RAM)
		|-> m_axis_tdata[21:16] == 6'd0)
		else $error("RAM address beyond 8 KiB");

endmodule

bind mmc3_bank_mapper_irq mmc3_checker u_mmc3_checker (.*);
